@@ src/psau_pkg.sv @@
package psau_pkg;

    // Item operation codes
    typedef enum logic [2:0] {
        OP_REG_WRITE   = 3'd0,
        OP_STATUS_READ = 3'd1,
        OP_DATA_ACCESS = 3'd2,
        OP_INC_X       = 3'd3,
        OP_INC_Y       = 3'd4,
        OP_COPY_X      = 3'd5,
        OP_COPY_Y      = 3'd6
    } opcode_t;

    // Register numbers for a register write
    localparam logic [2:0] REG_CONTROL = 3'd0;
    localparam logic [2:0] REG_MASK    = 3'd1;
    localparam logic [2:0] REG_SCROLL  = 3'd5;
    localparam logic [2:0] REG_ADDRESS = 3'd6;
    localparam logic [2:0] REG_DATA    = 3'd7;

    // Address layout and fetch bases
    localparam int unsigned ADDR_W        = 15;
    localparam int unsigned FETCH_W       = 14;
    localparam logic [13:0] TILE_BASE     = 14'h2000;
    localparam logic [13:0] ATTR_BASE     = 14'h23C0;
    localparam logic [4:0]  COARSE_MAX    = 5'd31;
    localparam logic [4:0]  COARSE_Y_LAST = 5'd29;
    localparam logic [2:0]  FINE_Y_MAX    = 3'd7;
    localparam logic [14:0] COPY_X_MASK   = 15'h041F;
    localparam logic [14:0] COPY_Y_MASK   = 15'h7BE0;

    typedef struct packed {
        logic [2:0] opcode;
        logic [2:0] reg_index;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  vram_address;
        logic [ADDR_W-1:0]  temp_address;
        logic [2:0]         fine_x_scroll;
        logic               write_toggle;
        logic [FETCH_W-1:0] tile_fetch_address;
        logic [FETCH_W-1:0] attribute_fetch_address;
        logic [2:0]         attribute_shift;
    } result_t;

endpackage

@@ src/ppu_scroll_address_unit.sv @@
// Scroll and video address unit of the picture unit.
// Item channel (item_valid / item_stall / item): one transaction per register
// write, status read, data-port access or render-gated scroll step.
// Result channel (result_valid / result_stall / result): exactly one
// transaction per item, carrying both addresses, fine X, the write toggle and
// the tile and attribute fetch addresses of the current address.
// An item waits in the item register until the result register is free; the
// state update then lands in the result register, which shows the result.
// Throughput: one item per cycle while the receiver does not stall; the whole
// update is one pass of logic between the item register and the result register.
// When the receiver stalls, the result register holds; the item register still
// takes one more transaction, then item_stall rises until the result drains.
// Reset clears both addresses, fine X, the toggle, the increment and render
// enables, and empties both registers.
module ppu_scroll_address_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  psau_pkg::item_t  item,
    output logic             result_valid,
    input  logic             result_stall,
    output psau_pkg::result_t result
);

    // Pipeline registers
    logic              item_valid_reg;
    psau_pkg::item_t   item_reg;
    logic              result_valid_reg;
    psau_pkg::result_t result_reg;
    psau_pkg::result_t result_next;

    // Architectural state
    logic [14:0] address_now_reg,  address_now_next;
    logic [14:0] address_pend_reg, address_pend_next;
    logic [2:0]  fine_x_reg,       fine_x_next;
    logic        toggle_reg,       toggle_next;
    logic        step32_reg,       step32_next;
    logic        show_bg_reg,      show_bg_next;
    logic        show_spr_reg,     show_spr_next;

    logic result_open;
    logic advance;
    logic item_take;

    // Handshake control
    assign result_open = !result_valid_reg || !result_stall;
    assign advance     = item_valid_reg && result_open;
    assign item_stall  = item_valid_reg && !result_open;
    assign item_take   = item_valid && !item_stall;

    // State update for the item in the item register
    always_comb
    begin
        logic        render;
        logic [14:0] v;
        logic [14:0] step;
        logic [4:0]  cx;
        logic [4:0]  cy;
        logic [7:0]  d;

        render = show_bg_reg || show_spr_reg;
        v      = address_now_reg;
        d      = item_reg.write_data;
        step   = step32_reg ? 15'd32 : 15'd1;
        cx     = v[4:0];
        cy     = v[9:5];

        address_now_next  = address_now_reg;
        address_pend_next = address_pend_reg;
        fine_x_next       = fine_x_reg;
        toggle_next       = toggle_reg;
        step32_next       = step32_reg;
        show_bg_next      = show_bg_reg;
        show_spr_next     = show_spr_reg;

        unique case (psau_pkg::opcode_t'(item_reg.opcode))
            psau_pkg::OP_REG_WRITE:
            begin
                unique case (item_reg.reg_index)
                    psau_pkg::REG_CONTROL:
                    begin
                        address_pend_next[11:10] = d[1:0];
                        step32_next              = d[2];
                    end
                    psau_pkg::REG_MASK:
                    begin
                        show_bg_next  = d[3];
                        show_spr_next = d[4];
                    end
                    psau_pkg::REG_SCROLL:
                    begin
                        if (!toggle_reg)
                        begin
                            fine_x_next            = d[2:0];
                            address_pend_next[4:0] = d[7:3];
                        end
                        else
                        begin
                            address_pend_next[14:12] = d[2:0];
                            address_pend_next[9:5]   = d[7:3];
                        end
                        toggle_next = !toggle_reg;
                    end
                    psau_pkg::REG_ADDRESS:
                    begin
                        if (!toggle_reg)
                        begin
                            address_pend_next[13:8] = d[5:0];
                            address_pend_next[14]   = 1'b0;
                        end
                        else
                        begin
                            address_pend_next[7:0] = d;
                            address_now_next       = {address_pend_reg[14:8], d};
                        end
                        toggle_next = !toggle_reg;
                    end
                    psau_pkg::REG_DATA:
                    begin
                        address_now_next = v + step;
                    end
                    default:
                    begin
                    end
                endcase
            end
            psau_pkg::OP_STATUS_READ:
            begin
                toggle_next = 1'b0;
            end
            psau_pkg::OP_DATA_ACCESS:
            begin
                address_now_next = v + step;
            end
            psau_pkg::OP_INC_X:
            begin
                if (render)
                begin
                    if (cx == psau_pkg::COARSE_MAX)
                    begin
                        address_now_next[4:0] = 5'd0;
                        address_now_next[10]  = !v[10];
                    end
                    else
                    begin
                        address_now_next[4:0] = cx + 5'd1;
                    end
                end
            end
            psau_pkg::OP_INC_Y:
            begin
                if (render)
                begin
                    if (v[14:12] != psau_pkg::FINE_Y_MAX)
                    begin
                        address_now_next[14:12] = v[14:12] + 3'd1;
                    end
                    else
                    begin
                        address_now_next[14:12] = 3'd0;
                        if (cy == psau_pkg::COARSE_Y_LAST)
                        begin
                            address_now_next[9:5] = 5'd0;
                            address_now_next[11]  = !v[11];
                        end
                        else if (cy == psau_pkg::COARSE_MAX)
                        begin
                            address_now_next[9:5] = 5'd0;
                        end
                        else
                        begin
                            address_now_next[9:5] = cy + 5'd1;
                        end
                    end
                end
            end
            psau_pkg::OP_COPY_X:
            begin
                if (render)
                begin
                    address_now_next = (v & ~psau_pkg::COPY_X_MASK)
                                     | (address_pend_reg & psau_pkg::COPY_X_MASK);
                end
            end
            psau_pkg::OP_COPY_Y:
            begin
                if (render)
                begin
                    address_now_next = (v & ~psau_pkg::COPY_Y_MASK)
                                     | (address_pend_reg & psau_pkg::COPY_Y_MASK);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result fields from the updated state
    always_comb
    begin
        logic [4:0] ncx;
        logic [4:0] ncy;

        ncx = address_now_next[4:0];
        ncy = address_now_next[9:5];

        result_next.vram_address       = address_now_next;
        result_next.temp_address       = address_pend_next;
        result_next.fine_x_scroll      = fine_x_next;
        result_next.write_toggle       = toggle_next;
        result_next.tile_fetch_address = psau_pkg::TILE_BASE
                                       | {2'b00, address_now_next[11:0]};
        result_next.attribute_fetch_address = psau_pkg::ATTR_BASE
                                            | {2'b00, address_now_next[11:10], 4'd0,
                                               ncy[4:2], 3'd0}
                                            | {11'd0, ncx[4:2]};
        result_next.attribute_shift    = {ncy[1], ncx[1], 1'b0};
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            address_now_reg  <= '0;
            address_pend_reg <= '0;
            fine_x_reg       <= '0;
            toggle_reg       <= 1'b0;
            step32_reg       <= 1'b0;
            show_bg_reg      <= 1'b0;
            show_spr_reg     <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                result_valid_reg <= 1'b1;
                address_now_reg  <= address_now_next;
                address_pend_reg <= address_pend_next;
                fine_x_reg       <= fine_x_next;
                toggle_reg       <= toggle_next;
                step32_reg       <= step32_next;
                show_bg_reg      <= show_bg_next;
                show_spr_reg     <= show_spr_next;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    // Reported address always matches the live state
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.vram_address == address_now_reg
                              && result_reg.temp_address == address_pend_reg))
        else $error("result does not match address state");

    // A status read always leaves the toggle clear
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.opcode == psau_pkg::OP_STATUS_READ)
        |=> !result_reg.write_toggle)
        else $error("status read left toggle set");

    // Second address write copies pending into current
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.opcode == psau_pkg::OP_REG_WRITE
         && item_reg.reg_index == psau_pkg::REG_ADDRESS && toggle_reg)
        |=> (address_now_reg == address_pend_reg))
        else $error("second address write did not load current address");

    // Scroll steps do nothing while rendering is off
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !show_bg_reg && !show_spr_reg
         && (item_reg.opcode == psau_pkg::OP_INC_X
             || item_reg.opcode == psau_pkg::OP_INC_Y
             || item_reg.opcode == psau_pkg::OP_COPY_X
             || item_reg.opcode == psau_pkg::OP_COPY_Y))
        |=> $stable(address_now_reg))
        else $error("scroll step changed address with rendering off");

    // Every item that moves on produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("item lost between stages");
`endif

endmodule

@@ dv/ppu_scroll_address_unit_checker.sv @@
module ppu_scroll_address_unit_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  psau_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  psau_pkg::result_t result,
    output int                errors,
    output int                checked,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the scroll and address state
    logic [psau_pkg::ADDR_W-1:0] cur_addr;
    logic [psau_pkg::ADDR_W-1:0] tmp_addr;
    logic [2:0]                  fine_x;
    logic                        toggle;
    logic                        step32;
    logic                        bg_shown;
    logic                        spr_shown;

    // Predicted results still waiting for their transaction on the result side
    psau_pkg::result_t views_due[$];
    psau_pkg::result_t want;

    // Apply one item to the shadow state and return the view that follows it
    function automatic psau_pkg::result_t advance_scroll(input psau_pkg::item_t it);
        logic              render;
        logic [7:0]        d;
        psau_pkg::result_t view;
        render = bg_shown || spr_shown;
        d      = it.write_data;
        case (it.opcode)
            psau_pkg::OP_REG_WRITE:
            begin
                case (it.reg_index)
                    psau_pkg::REG_CONTROL:
                    begin
                        tmp_addr[11:10] = d[1:0];
                        step32          = d[2];
                    end
                    psau_pkg::REG_MASK:
                    begin
                        bg_shown  = d[3];
                        spr_shown = d[4];
                    end
                    psau_pkg::REG_SCROLL:
                    begin
                        if (!toggle)
                        begin
                            fine_x        = d[2:0];
                            tmp_addr[4:0] = d[7:3];
                        end
                        else
                        begin
                            tmp_addr[14:12] = d[2:0];
                            tmp_addr[9:5]   = d[7:3];
                        end
                        toggle = !toggle;
                    end
                    psau_pkg::REG_ADDRESS:
                    begin
                        if (!toggle)
                            tmp_addr = {1'b0, d[5:0], tmp_addr[7:0]};
                        else
                        begin
                            tmp_addr[7:0] = d;
                            cur_addr      = tmp_addr;
                        end
                        toggle = !toggle;
                    end
                    psau_pkg::REG_DATA:
                        cur_addr = cur_addr + (step32 ? 15'd32 : 15'd1);
                    default:
                        ;
                endcase
            end
            psau_pkg::OP_STATUS_READ:
                toggle = 1'b0;
            psau_pkg::OP_DATA_ACCESS:
                cur_addr = cur_addr + (step32 ? 15'd32 : 15'd1);
            psau_pkg::OP_INC_X:
            begin
                if (render)
                begin
                    // coarse X rolls into the other horizontal nametable
                    if (cur_addr[4:0] == psau_pkg::COARSE_MAX)
                    begin
                        cur_addr[4:0] = '0;
                        cur_addr[10]  = !cur_addr[10];
                    end
                    else
                        cur_addr[4:0] = cur_addr[4:0] + 5'd1;
                end
            end
            psau_pkg::OP_INC_Y:
            begin
                if (render)
                begin
                    if (cur_addr[14:12] != psau_pkg::FINE_Y_MAX)
                        cur_addr[14:12] = cur_addr[14:12] + 3'd1;
                    else
                    begin
                        cur_addr[14:12] = '0;
                        // row 29 flips vertical nametable, row 31 wraps silently
                        if (cur_addr[9:5] == psau_pkg::COARSE_Y_LAST)
                        begin
                            cur_addr[9:5] = '0;
                            cur_addr[11]  = !cur_addr[11];
                        end
                        else if (cur_addr[9:5] == psau_pkg::COARSE_MAX)
                            cur_addr[9:5] = '0;
                        else
                            cur_addr[9:5] = cur_addr[9:5] + 5'd1;
                    end
                end
            end
            psau_pkg::OP_COPY_X:
            begin
                if (render)
                    cur_addr = (cur_addr & ~psau_pkg::COPY_X_MASK)
                             | (tmp_addr & psau_pkg::COPY_X_MASK);
            end
            psau_pkg::OP_COPY_Y:
            begin
                if (render)
                    cur_addr = (cur_addr & ~psau_pkg::COPY_Y_MASK)
                             | (tmp_addr & psau_pkg::COPY_Y_MASK);
            end
            default:
                ;
        endcase

        view.vram_address            = cur_addr;
        view.temp_address            = tmp_addr;
        view.fine_x_scroll           = fine_x;
        view.write_toggle            = toggle;
        view.tile_fetch_address      = psau_pkg::TILE_BASE | {2'b00, cur_addr[11:0]};
        view.attribute_fetch_address = psau_pkg::ATTR_BASE
                                     | {2'b00, cur_addr[11:10], 4'b0000,
                                        cur_addr[9:7], cur_addr[4:2]};
        view.attribute_shift         = {cur_addr[6], cur_addr[1], 1'b0};
        return view;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (got_v !== exp_v)
        begin
            errors++;
            if (errors <= 10)
                $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h",
                         $realtime, name, exp_v, got_v);
        end
    endtask

    // Compare finished transactions first, then queue the prediction for a new item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_addr  = '0;
            tmp_addr  = '0;
            fine_x    = '0;
            toggle    = 1'b0;
            step32    = 1'b0;
            bg_shown  = 1'b0;
            spr_shown = 1'b0;
            views_due.delete();
            errors      = 0;
            checked     = 0;
            outstanding = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (views_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("[%0t] result transaction with nothing expected: 0x%0h",
                                 $realtime, result);
                end
                else
                begin
                    want = views_due.pop_front();
                    check_field("vram_address", 16'(want.vram_address),
                                16'(result.vram_address));
                    check_field("temp_address", 16'(want.temp_address),
                                16'(result.temp_address));
                    check_field("fine_x_scroll", 16'(want.fine_x_scroll),
                                16'(result.fine_x_scroll));
                    check_field("write_toggle", 16'(want.write_toggle),
                                16'(result.write_toggle));
                    check_field("tile_fetch_address", 16'(want.tile_fetch_address),
                                16'(result.tile_fetch_address));
                    check_field("attribute_fetch_address",
                                16'(want.attribute_fetch_address),
                                16'(result.attribute_fetch_address));
                    check_field("attribute_shift", 16'(want.attribute_shift),
                                16'(result.attribute_shift));
                    checked++;
                end
            end
            if (item_valid && !item_stall)
                views_due.push_back(advance_scroll(item));
            outstanding = views_due.size();
        end
    end

endmodule

@@ dv/ppu_scroll_address_unit_tb.sv @@
module ppu_scroll_address_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_ITEMS  = 900;
    localparam int          CALM_TAIL     = 150;
    localparam int          HOLD_CYCLES   = 80;
    localparam int          HOLD_AFTER    = 400;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam logic [2:0]  OP_RESERVED   = 3'd7;
    localparam logic [2:0]  REG_UNUSED_LO = 3'd2;
    localparam logic [2:0]  REG_UNUSED_HI = 3'd4;
    localparam logic [7:0]  SHOW_BG       = 8'h08;
    localparam logic [7:0]  SHOW_SPR      = 8'h10;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    psau_pkg::item_t   item;
    logic              result_valid;
    logic              result_stall;
    psau_pkg::result_t result;

    int errors;
    int checked;
    int outstanding;
    int items_sent;
    int directed_count;
    int results_seen;
    int cycles;
    bit calm;
    bit hold_done;

    ppu_scroll_address_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    ppu_scroll_address_unit_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .errors       (errors),
        .checked      (checked),
        .outstanding  (outstanding)
    );

    always #10 clk = ~clk;

    // Watchdog and result transaction count
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (result_valid && !result_stall)
            results_seen <= results_seen + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d predictions outstanding",
                     cycles, outstanding);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // One transaction on the item side, then maybe a burst of idle cycles
    task automatic send(input logic [2:0] op, input logic [2:0] idx, input logic [7:0] d);
        item_valid <= 1'b1;
        item       <= psau_pkg::item_t'{op, idx, d};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 9))
                @(posedge clk);
        end
    endtask

    task automatic send_plain(input logic [2:0] op);
        send(op, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    endtask

    // Result side: random stall bursts plus one long hold-off
    initial
    begin
        hold_done = 1'b0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && !hold_done && results_seen >= HOLD_AFTER)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                result_stall <= 1'b0;
                hold_done = 1'b1;
            end
            else if (rst_n && !calm && $urandom_range(0, 6) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 9))
                    @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int         r;
        logic [7:0] mask_byte;
        items_sent = 0;
        calm       = 1'b0;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Render off: steps must leave the address alone
        send_plain(psau_pkg::OP_INC_X);
        send_plain(psau_pkg::OP_COPY_Y);
        send_plain(OP_RESERVED);
        // Control extremes and both data-port steps
        send(psau_pkg::OP_REG_WRITE, psau_pkg::REG_CONTROL, 8'hFF);
        send_plain(psau_pkg::OP_DATA_ACCESS);
        send(psau_pkg::OP_REG_WRITE, psau_pkg::REG_DATA, 8'h5A);
        send(psau_pkg::OP_REG_WRITE, psau_pkg::REG_CONTROL, 8'h00);
        send_plain(psau_pkg::OP_DATA_ACCESS);
        // Sprites alone enable rendering; coarse X 31 and row 31 with fine Y 7
        send(psau_pkg::OP_REG_WRITE, psau_pkg::REG_MASK, SHOW_SPR);
        send(psau_pkg::OP_REG_WRITE, psau_pkg::REG_SCROLL, 8'hFF);
        send_plain(psau_pkg::OP_STATUS_READ);
        send(psau_pkg::OP_REG_WRITE, psau_pkg::REG_SCROLL, 8'hFF);
        send(psau_pkg::OP_REG_WRITE, psau_pkg::REG_SCROLL, 8'hFF);
        send_plain(psau_pkg::OP_COPY_X);
        send_plain(psau_pkg::OP_COPY_Y);
        send_plain(psau_pkg::OP_INC_X);
        send_plain(psau_pkg::OP_INC_Y);
        // Row 29 with fine Y 7 flips the vertical nametable
        send(psau_pkg::OP_REG_WRITE, psau_pkg::REG_SCROLL, 8'h00);
        send(psau_pkg::OP_REG_WRITE, psau_pkg::REG_SCROLL, 8'hEF);
        send_plain(psau_pkg::OP_COPY_Y);
        send_plain(psau_pkg::OP_INC_Y);
        // Address pair at its extremes, unused registers, plain fine Y step
        send(psau_pkg::OP_REG_WRITE, psau_pkg::REG_ADDRESS, 8'hFF);
        send(psau_pkg::OP_REG_WRITE, psau_pkg::REG_ADDRESS, 8'hFF);
        send(psau_pkg::OP_REG_WRITE, psau_pkg::REG_MASK, SHOW_BG);
        send(psau_pkg::OP_REG_WRITE, REG_UNUSED_LO, 8'hFF);
        send(psau_pkg::OP_REG_WRITE, REG_UNUSED_HI, 8'h00);
        send(psau_pkg::OP_REG_WRITE, psau_pkg::REG_ADDRESS, 8'h00);
        send(psau_pkg::OP_REG_WRITE, psau_pkg::REG_ADDRESS, 8'h00);
        send_plain(psau_pkg::OP_INC_Y);
        directed_count = items_sent;

        // Random part: mostly rendering with well-formed register pairs
        while (items_sent < directed_count + RANDOM_ITEMS)
        begin
            calm = (items_sent >= directed_count + RANDOM_ITEMS - CALM_TAIL);
            r = $urandom_range(0, 99);
            if (r < 6)
            begin
                send_plain(psau_pkg::OP_STATUS_READ);
                send(psau_pkg::OP_REG_WRITE, psau_pkg::REG_SCROLL,
                     8'($urandom_range(0, 255)));
                send(psau_pkg::OP_REG_WRITE, psau_pkg::REG_SCROLL,
                     8'($urandom_range(0, 255)));
            end
            else if (r < 11)
            begin
                send_plain(psau_pkg::OP_STATUS_READ);
                send(psau_pkg::OP_REG_WRITE, psau_pkg::REG_ADDRESS,
                     8'($urandom_range(0, 255)));
                send(psau_pkg::OP_REG_WRITE, psau_pkg::REG_ADDRESS,
                     8'($urandom_range(0, 255)));
            end
            else if (r < 15)
                send(psau_pkg::OP_REG_WRITE, psau_pkg::REG_CONTROL,
                     8'($urandom_range(0, 255)));
            else if (r < 21)
            begin
                mask_byte = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 6) != 0)
                    mask_byte = mask_byte | SHOW_BG;
                send(psau_pkg::OP_REG_WRITE, psau_pkg::REG_MASK, mask_byte);
            end
            else if (r < 24)
                send_plain(psau_pkg::OP_REG_WRITE);
            else if (r < 28)
                send_plain(psau_pkg::OP_STATUS_READ);
            else if (r < 36)
                send_plain(psau_pkg::OP_DATA_ACCESS);
            else if (r < 60)
                send_plain(psau_pkg::OP_INC_X);
            else if (r < 75)
                send_plain(psau_pkg::OP_INC_Y);
            else if (r < 83)
                send_plain(psau_pkg::OP_COPY_X);
            else if (r < 91)
                send_plain(psau_pkg::OP_COPY_Y);
            else if (r < 94)
                send_plain(OP_RESERVED);
            else
                send(psau_pkg::OP_REG_WRITE, psau_pkg::REG_DATA,
                     8'($urandom_range(0, 255)));
        end
        item_valid <= 1'b0;

        // Drain, then allow for the pipeline latency
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (4)
            @(negedge clk);

        $display("Sent %0d items (%0d directed), checked %0d results, %0d mismatches",
                 items_sent, directed_count, checked, errors);
        $display("Covered register pairs, render-gated steps, coarse wraps and a %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
